>>> hw/rtl/matrix_line_sum_max_unit_macros.svh
// Assertion helpers for the line sum maximum block.
`ifndef MATRIX_LINE_SUM_MAX_UNIT_MACROS_SVH
`define MATRIX_LINE_SUM_MAX_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MLSM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition never occurs.
`define MLSM_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

>>> hw/rtl/mlsm_pkg.sv
package mlsm_pkg;

   localparam int MAX_SIDE   = 128;
   localparam int IDX_WIDTH  = $clog2(MAX_SIDE);
   localparam int ELEM_WIDTH = 16;
   localparam int SUM_WIDTH  = 24;
   localparam int OUT_WIDTH  = 23;
   localparam int SIDE_WIDTH = 8;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_WIDTH = 3;

   localparam logic [SIDE_WIDTH-1:0] SIDE_RESET      = SIDE_WIDTH'(100);
   localparam logic [IDX_WIDTH-1:0]  SIDE_LAST_RESET = IDX_WIDTH'(99);

   localparam logic REG_SIDE_LEN = 1'b0;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                        shift;
      logic signed [SUM_WIDTH-1:0] value;
   } col_bus_type;

endpackage

>>> hw/rtl/mlsm_cell.sv
module mlsm_cell (
   input  logic                                 clock,
   input  mlsm_pkg::col_bus_type                bus,
   input  logic                                 is_tail,
   input  logic signed [mlsm_pkg::SUM_WIDTH-1:0] neigh_sum,
   output logic signed [mlsm_pkg::SUM_WIDTH-1:0] sum
);

   logic signed [mlsm_pkg::SUM_WIDTH-1:0] sum_ff;
   logic signed [mlsm_pkg::SUM_WIDTH-1:0] sum_in;

   // The tail cell takes the freshly updated column; the others pass along.
   assign sum_in = is_tail ? bus.value : neigh_sum;

   always_ff @(posedge clock) begin
      if (bus.shift) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

>>> hw/rtl/mlsm_col_chain.sv
module mlsm_col_chain (
   input  logic                                 clock,
   input  mlsm_pkg::col_bus_type                bus,
   input  logic [mlsm_pkg::IDX_WIDTH-1:0]        side_last,
   output logic signed [mlsm_pkg::SUM_WIDTH-1:0] head_sum
);

   logic signed [mlsm_pkg::SUM_WIDTH-1:0] cell_sum [mlsm_pkg::MAX_SIDE];

   for (genvar i = 0; i < mlsm_pkg::MAX_SIDE; i++) begin : g_cell
      logic                                 tail;
      logic signed [mlsm_pkg::SUM_WIDTH-1:0] neigh;

      assign tail = (side_last == mlsm_pkg::IDX_WIDTH'(i));

      if (i == mlsm_pkg::MAX_SIDE - 1) begin : g_end
         assign neigh = bus.value;
      end else begin : g_mid
         assign neigh = cell_sum[i+1];
      end

      mlsm_cell u_cell (
         .clock     (clock),
         .bus       (bus),
         .is_tail   (tail),
         .neigh_sum (neigh),
         .sum       (cell_sum[i])
      );
   end

   // Outside row 0, cell 0 holds the sum of the column the next item lands in.
   assign head_sum = cell_sum[0];

endmodule

>>> hw/rtl/matrix_line_sum_max_unit.sv
// Line sum maximum of a square matrix.
// Items on the req_ channel carry one signed element each, in row-major
// order; side_len (csr register 0, 1..128, 0 acts as 1, above 128 as 128)
// sets the matrix side. After the last element of a matrix one item on the
// rsp_ channel carries the largest row, column, main-diagonal or
// anti-diagonal sum; other elements produce nothing.
// Throughput: one element per cycle while req_stall is low, set by the column
// accumulator chain, 128 cells of which the first side_len turn one column
// per accepted element. A matrix's last element is accumulated into the fold
// candidates on accept; folding them into the maximum registers the result.
// Reset clears position, sums and maximum and sets side_len to 100; a write
// to side_len does the same for the matrix in progress. Column accumulators
// are overwritten by row 0 and need no clearing.
// When rsp_stall holds a result and another finished matrix is ready to
// fold, req_stall rises until the waiting result is taken; otherwise
// elements keep flowing while the result waits.
`include "matrix_line_sum_max_unit_macros.svh"

module matrix_line_sum_max_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [mlsm_pkg::ELEM_WIDTH-1:0]  req_element,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [mlsm_pkg::OUT_WIDTH-1:0]   rsp_max_sum,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [mlsm_pkg::ADDR_WIDTH-1:0]          csr_paddr,
   input  logic [mlsm_pkg::DATA_WIDTH-1:0]          csr_pwdata,
   output logic [mlsm_pkg::DATA_WIDTH-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   localparam int SW = mlsm_pkg::SUM_WIDTH;
   localparam int IW = mlsm_pkg::IDX_WIDTH;

   function automatic logic signed [SW-1:0] smax(logic signed [SW-1:0] a,
                                                 logic signed [SW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // configuration
   logic [mlsm_pkg::SIDE_WIDTH-1:0] side_len_ff, side_len_in;
   logic [IW-1:0]                   side_last_ff, side_last_in;
   logic                            csr_write;
   logic [mlsm_pkg::SIDE_WIDTH-1:0] wr_side;

   // position and accumulators
   logic [IW-1:0]          row_ff, row_in, col_ff, col_in;
   logic signed [SW-1:0]   row_sum_ff, row_sum_in;
   logic signed [SW-1:0]   main_ff, main_in, anti_ff, anti_in;
   logic signed [SW-1:0]   best_ff, best_in;

   // fold candidates
   logic                   cand_valid_ff, cand_valid_in, cand_last_ff, cand_last_in;
   logic signed [SW-1:0]   cand_row_ff, cand_row_in, cand_col_ff, cand_col_in;
   logic signed [SW-1:0]   cand_main_ff, cand_main_in, cand_anti_ff, cand_anti_in;

   // result
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [mlsm_pkg::OUT_WIDTH-1:0] rsp_max_sum_ff, rsp_max_sum_in;

   logic                   accept, blocked, fire;
   logic                   col_end, row_end, last, on_main, on_anti;
   logic signed [SW-1:0]   elem_ext, head_sum, col_new, row_new, main_new, anti_new;
   logic signed [SW-1:0]   fold_rc, fold_d, fold_max;
   mlsm_pkg::col_bus_type  bus;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign wr_side    = csr_pwdata[mlsm_pkg::SIDE_WIDTH-1:0];

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         mlsm_pkg::REG_SIDE_LEN: csr_prdata = mlsm_pkg::DATA_WIDTH'(side_len_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // Keep the written side length and its saturated index of the last row and column.
   always_comb begin
      side_len_in  = side_len_ff;
      side_last_in = side_last_ff;
      if (csr_write && csr_paddr[2] == mlsm_pkg::REG_SIDE_LEN) begin
         side_len_in = wr_side;
         if (wr_side == '0) begin
            side_last_in = '0;
         end else if (wr_side > mlsm_pkg::SIDE_WIDTH'(mlsm_pkg::MAX_SIDE)) begin
            side_last_in = IW'(mlsm_pkg::MAX_SIDE - 1);
         end else begin
            side_last_in = IW'(wr_side - mlsm_pkg::SIDE_WIDTH'(1));
         end
      end
   end

   // Hold elements and the fold while a finished matrix waits behind a stalled result.
   assign blocked   = cand_valid_ff && cand_last_ff && rsp_valid_ff && rsp_stall;
   assign req_stall = blocked;
   assign accept    = req_valid && !req_stall;
   assign fire      = cand_valid_ff && !blocked;

   assign elem_ext = SW'(req_element);
   assign col_end  = (col_ff == side_last_ff);
   assign row_end  = (row_ff == side_last_ff);
   assign last     = col_end && row_end;
   assign on_main  = (row_ff == col_ff);
   assign on_anti  = ((IW+1)'(row_ff) + (IW+1)'(col_ff)) == (IW+1)'(side_last_ff);

   // Row 0 starts a column afresh.
   assign col_new  = (row_ff == '0) ? elem_ext : head_sum + elem_ext;
   assign row_new  = row_sum_ff + elem_ext;
   assign main_new = on_main ? main_ff + elem_ext : main_ff;
   assign anti_new = on_anti ? anti_ff + elem_ext : anti_ff;

   assign bus.shift = accept;
   assign bus.value = col_new;

   mlsm_col_chain u_chain (
      .clock     (clock),
      .bus       (bus),
      .side_last (side_last_ff),
      .head_sum  (head_sum)
   );

   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      row_sum_in    = row_sum_ff;
      main_in       = main_ff;
      anti_in       = anti_ff;
      cand_row_in   = cand_row_ff;
      cand_col_in   = cand_col_ff;
      cand_main_in  = cand_main_ff;
      cand_anti_in  = cand_anti_ff;
      cand_last_in  = cand_last_ff;
      cand_valid_in = blocked ? cand_valid_ff : 1'b0;
      if (accept) begin
         cand_valid_in = 1'b1;
         cand_last_in  = last;
         cand_row_in   = col_end ? row_new : mlsm_pkg::SUM_MIN;
         cand_col_in   = row_end ? col_new : mlsm_pkg::SUM_MIN;
         cand_main_in  = last ? main_new : mlsm_pkg::SUM_MIN;
         cand_anti_in  = last ? anti_new : mlsm_pkg::SUM_MIN;
         row_sum_in    = col_end ? '0 : row_new;
         main_in       = last ? '0 : main_new;
         anti_in       = last ? '0 : anti_new;
         col_in        = col_end ? '0 : col_ff + IW'(1);
         if (col_end) begin
            row_in = row_end ? '0 : row_ff + IW'(1);
         end
      end
   end

   assign fold_rc  = smax(cand_row_ff, cand_col_ff);
   assign fold_d   = smax(cand_main_ff, cand_anti_ff);
   assign fold_max = smax(best_ff, smax(fold_rc, fold_d));

   always_comb begin
      best_in        = best_ff;
      rsp_max_sum_in = rsp_max_sum_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (fire) begin
         best_in = cand_last_ff ? mlsm_pkg::SUM_MIN : fold_max;
         if (cand_last_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_max_sum_in = fold_max[mlsm_pkg::OUT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_len_ff   <= mlsm_pkg::SIDE_RESET;
         side_last_ff  <= mlsm_pkg::SIDE_LAST_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         row_sum_ff    <= '0;
         main_ff       <= '0;
         anti_ff       <= '0;
         best_ff       <= mlsm_pkg::SUM_MIN;
         cand_valid_ff <= 1'b0;
         cand_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (csr_write && csr_paddr[2] == mlsm_pkg::REG_SIDE_LEN) begin
         // Drop the matrix in progress.
         side_len_ff   <= side_len_in;
         side_last_ff  <= side_last_in;
         row_ff        <= '0;
         col_ff        <= '0;
         row_sum_ff    <= '0;
         main_ff       <= '0;
         anti_ff       <= '0;
         best_ff       <= mlsm_pkg::SUM_MIN;
         cand_valid_ff <= cand_valid_in;
         cand_last_ff  <= cand_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         row_sum_ff    <= row_sum_in;
         main_ff       <= main_in;
         anti_ff       <= anti_in;
         best_ff       <= best_in;
         cand_valid_ff <= cand_valid_in;
         cand_last_ff  <= cand_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_row_ff    <= cand_row_in;
      cand_col_ff    <= cand_col_in;
      cand_main_ff   <= cand_main_in;
      cand_anti_ff   <= cand_anti_in;
      rsp_max_sum_ff <= rsp_max_sum_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_sum = rsp_max_sum_ff;

   `MLSM_ASSERT(a_pos_in_range, (row_ff <= side_last_ff) && (col_ff <= side_last_ff), "position beyond side length")
   `MLSM_ASSERT(a_rsp_from_last, $rose(rsp_valid_ff) |-> $past(cand_valid_ff && cand_last_ff), "result without last element")
   `MLSM_ASSERT(a_best_cleared, (fire && cand_last_ff && !csr_write) |=> (best_ff == mlsm_pkg::SUM_MIN), "maximum not cleared after matrix")
   `MLSM_NEVER(a_no_accept_blocked, accept && blocked, "element accepted while fold is held")

endmodule

>>> dv/matrix_line_sum_max_unit_tb.sv
module matrix_line_sum_max_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mlsm_pkg::ADDR_WIDTH-1:0] SIDE_LEN_ADDR = mlsm_pkg::ADDR_WIDTH'(0);
   localparam logic [mlsm_pkg::ADDR_WIDTH-1:0] UNUSED_ADDR   = mlsm_pkg::ADDR_WIDTH'(4);
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int DIRECTED_ROWS  = 31;
   localparam int EXTREME_SIDE   = 8;

   typedef enum logic {ROW_WRITE, ROW_ELEM} row_kind_type;
   typedef enum int {MODE_FULL, MODE_SMALL, MODE_EXTREME, MODE_HIGH, MODE_LOW} elem_mode_type;

   typedef struct packed {
      row_kind_type                          kind;
      logic [mlsm_pkg::ADDR_WIDTH-1:0]       addr;
      logic [mlsm_pkg::DATA_WIDTH-1:0]       value;
      logic                                  has_want;
      logic signed [mlsm_pkg::OUT_WIDTH-1:0] want;
   } stim_row_type;

   logic                                     clock;
   logic                                     reset;
   logic                                     req_valid;
   logic                                     req_stall;
   logic signed [mlsm_pkg::ELEM_WIDTH-1:0]   req_element;
   logic                                     rsp_valid;
   logic                                     rsp_stall = 1'b0;
   logic signed [mlsm_pkg::OUT_WIDTH-1:0]    rsp_max_sum;
   logic                                     csr_psel;
   logic                                     csr_penable;
   logic                                     csr_pwrite;
   logic [mlsm_pkg::ADDR_WIDTH-1:0]          csr_paddr;
   logic [mlsm_pkg::DATA_WIDTH-1:0]          csr_pwdata;
   logic [mlsm_pkg::DATA_WIDTH-1:0]          csr_prdata;
   logic                                     csr_pready;

   // predictor state
   logic [mlsm_pkg::SIDE_WIDTH-1:0]          side_reg;
   logic signed [mlsm_pkg::SUM_WIDTH-1:0]    col_total [mlsm_pkg::MAX_SIDE];
   logic signed [mlsm_pkg::SUM_WIDTH-1:0]    row_total;
   logic signed [mlsm_pkg::SUM_WIDTH-1:0]    main_total;
   logic signed [mlsm_pkg::SUM_WIDTH-1:0]    anti_total;
   logic signed [mlsm_pkg::SUM_WIDTH-1:0]    best_total;
   int unsigned                              row_pos;
   int unsigned                              col_pos;

   logic signed [mlsm_pkg::OUT_WIDTH-1:0]    line_max_queue [$];
   bit                                       quiet = 1'b0;
   int                                       hold_left = 0;
   int                                       error_count = 0;
   int                                       elements_sent = 0;
   int                                       maxima_checked = 0;
   int                                       writes_done = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_WRITE, SIDE_LEN_ADDR, 1,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 32767,  1'b1, 32767},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -32768, 1'b1, -32768},
      '{ROW_WRITE, SIDE_LEN_ADDR, 0,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -1,     1'b1, -1},
      '{ROW_WRITE, SIDE_LEN_ADDR, 2,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -32768, 1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -32768, 1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -32768, 1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -32768, 1'b1, -65536},
      '{ROW_WRITE, SIDE_LEN_ADDR, 3,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -5,     1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -5,     1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 9,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -5,     1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 9,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -5,     1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 9,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -5,     1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, -5,     1'b0, 0},
      '{ROW_WRITE, SIDE_LEN_ADDR, 3,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 100,    1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 200,    1'b0, 0},
      // abandon the partial matrix
      '{ROW_WRITE, SIDE_LEN_ADDR, 1,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 7,      1'b1, 7},
      '{ROW_WRITE, SIDE_LEN_ADDR, 2,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 10,     1'b0, 0},
      // unmapped address must leave the matrix in progress alone
      '{ROW_WRITE, UNUSED_ADDR,   1,      1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 20,     1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 30,     1'b0, 0},
      '{ROW_ELEM,  SIDE_LEN_ADDR, 40,     1'b0, 0}
   };

   matrix_line_sum_max_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_element (req_element),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_max_sum (rsp_max_sum),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void clear_position();
      row_total  = '0;
      main_total = '0;
      anti_total = '0;
      best_total = mlsm_pkg::SUM_MIN;
      row_pos    = 0;
      col_pos    = 0;
   endfunction

   function automatic void keep_larger(input logic signed [mlsm_pkg::SUM_WIDTH-1:0] s);
      if (s > best_total) best_total = s;
   endfunction

   function automatic bit accumulate_element(
         input  logic signed [mlsm_pkg::ELEM_WIDTH-1:0] e,
         output logic signed [mlsm_pkg::OUT_WIDTH-1:0]  line_max);
      int unsigned n;
      int unsigned c;
      logic signed [mlsm_pkg::SUM_WIDTH-1:0] v;
      n = (side_reg == 0) ? 1 :
          (side_reg > mlsm_pkg::MAX_SIDE) ? mlsm_pkg::MAX_SIDE : side_reg;
      v = e;
      c = col_pos % mlsm_pkg::MAX_SIDE;
      line_max = '0;
      // row 0 overwrites the column store
      if (row_pos == 0) col_total[c] = v;
      else col_total[c] = col_total[c] + v;
      row_total = row_total + v;
      if (row_pos == col_pos) main_total = main_total + v;
      if (row_pos + col_pos == n - 1) anti_total = anti_total + v;
      if (col_pos >= n - 1) begin
         keep_larger(row_total);
         row_total = '0;
      end
      if (row_pos >= n - 1) keep_larger(col_total[c]);
      col_pos++;
      if (col_pos >= n) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= n) begin
            keep_larger(main_total);
            keep_larger(anti_total);
            line_max = best_total[mlsm_pkg::OUT_WIDTH-1:0];
            clear_position();
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic signed [mlsm_pkg::ELEM_WIDTH-1:0] pick_element(
         input elem_mode_type mode);
      logic [31:0] raw;
      raw = $urandom();
      case (mode)
         MODE_SMALL: return mlsm_pkg::ELEM_WIDTH'(int'($urandom_range(0, 16)) - 8);
         MODE_EXTREME: begin
            case (raw[17:16])
               2'd0: return 16'sh7fff;
               2'd1: return 16'sh8000;
               2'd2: return '0;
               default: return raw[mlsm_pkg::ELEM_WIDTH-1:0];
            endcase
         end
         MODE_HIGH: return mlsm_pkg::ELEM_WIDTH'($urandom_range(20000, 32767));
         MODE_LOW: return mlsm_pkg::ELEM_WIDTH'(-int'($urandom_range(20000, 32768)));
         default: return raw[mlsm_pkg::ELEM_WIDTH-1:0];
      endcase
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic signed [mlsm_pkg::OUT_WIDTH-1:0] got,
                                  input logic signed [mlsm_pkg::OUT_WIDTH-1:0] want);
      $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic write_register(input logic [mlsm_pkg::ADDR_WIDTH-1:0] addr,
                                 input logic [mlsm_pkg::DATA_WIDTH-1:0] data);
      req_valid <= 1'b0;
      while (line_max_queue.size() != 0) @(posedge clock);
      // let the last elements settle through the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == SIDE_LEN_ADDR) begin
         side_reg = data[mlsm_pkg::SIDE_WIDTH-1:0];
         clear_position();
      end
      writes_done++;
   endtask

   task automatic send_element(input logic signed [mlsm_pkg::ELEM_WIDTH-1:0] e,
                               input bit has_want,
                               input logic signed [mlsm_pkg::OUT_WIDTH-1:0] want);
      int gap;
      bit done;
      logic signed [mlsm_pkg::OUT_WIDTH-1:0] predicted;
      gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_element <= e;
      do @(posedge clock); while (req_stall);
      done = accumulate_element(e, predicted);
      if (has_want) line_max_queue.push_back(want);
      else if (done) line_max_queue.push_back(predicted);
      elements_sent++;
   endtask

   task automatic send_matrix_run(input int count, input elem_mode_type mode);
      for (int i = 0; i < count; i++) send_element(pick_element(mode), 1'b0, '0);
   endtask

   // result side: check and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (line_max_queue.size() == 0) begin
               report_mismatch("max_sum with nothing expected", rsp_max_sum, '0);
            end else begin
               if (rsp_max_sum !== line_max_queue[0])
                  report_mismatch("max_sum", rsp_max_sum, line_max_queue[0]);
               void'(line_max_queue.pop_front());
               maxima_checked++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 4) == 0) hold_left = idle_len();
         end
      end
   end

   initial begin : watchdog
      int idle_count;
      idle_count = 0;
      while (idle_count < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
            idle_count = 0;
         else
            idle_count++;
      end
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int random_items;
      int n;
      int count;
      int pick;
      logic [mlsm_pkg::DATA_WIDTH-1:0] data;
      elem_mode_type mode;
      random_items = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_element <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      side_reg = mlsm_pkg::SIDE_RESET;
      clear_position();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one row at the side length left by reset, abandoned by the first write
      send_matrix_run(int'(mlsm_pkg::SIDE_RESET), MODE_FULL);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE)
            write_register(directed_rows[i].addr, directed_rows[i].value);
         else
            send_element(directed_rows[i].value[mlsm_pkg::ELEM_WIDTH-1:0],
                         directed_rows[i].has_want, directed_rows[i].want);
      end

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         data = $urandom();
         if (pick < 8) data[mlsm_pkg::SIDE_WIDTH-1:0] = '0;
         else if (pick < 16)
            data[mlsm_pkg::SIDE_WIDTH-1:0] = mlsm_pkg::SIDE_WIDTH'($urandom_range(129, 255));
         else if (pick < 30)
            data[mlsm_pkg::SIDE_WIDTH-1:0] = mlsm_pkg::SIDE_WIDTH'($urandom_range(9, 16));
         else
            data[mlsm_pkg::SIDE_WIDTH-1:0] = mlsm_pkg::SIDE_WIDTH'($urandom_range(1, 8));
         quiet = ($urandom_range(0, 5) == 0);
         write_register(SIDE_LEN_ADDR, data);
         if ($urandom_range(0, 7) == 0) write_register(UNUSED_ADDR, $urandom());
         n = (side_reg == 0) ? 1 :
             (side_reg > mlsm_pkg::MAX_SIDE) ? mlsm_pkg::MAX_SIDE : side_reg;
         if (n == mlsm_pkg::MAX_SIDE) begin
            // saturated side: a partial matrix, abandoned by the next write
            count = $urandom_range(1, 200);
         end else begin
            count = (n > 8) ? n * n : int'($urandom_range(1, 4)) * n * n;
            if (n > 1 && $urandom_range(0, 4) == 0) count += $urandom_range(1, n * n - 1);
         end
         mode = elem_mode_type'($urandom_range(0, 4));
         send_matrix_run(count, mode);
         random_items += count;
      end

      // saturated side for two rows, then a small side at both ends of the range
      quiet = 1'b0;
      write_register(SIDE_LEN_ADDR, mlsm_pkg::DATA_WIDTH'(255));
      for (int i = 0; i < 2 * mlsm_pkg::MAX_SIDE; i++) send_element(16'sh8000, 1'b0, '0);
      write_register(SIDE_LEN_ADDR, mlsm_pkg::DATA_WIDTH'(EXTREME_SIDE));
      for (int i = 0; i < EXTREME_SIDE * EXTREME_SIDE; i++) send_element(16'sh8000, 1'b0, '0);
      for (int i = 0; i < EXTREME_SIDE * EXTREME_SIDE; i++) send_element(16'sh7fff, 1'b0, '0);

      req_valid <= 1'b0;
      while (line_max_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("run covered %0d elements, %0d line maxima checked, %0d register writes",
               elements_sent, maxima_checked, writes_done);
      $display("sides from 0 to 255 with saturation, abandoned and back-to-back matrices");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
